// ===== sv/swds_pkg.sv =====
// Shared types and constants for the sliding-window duration statistics block.
package swds_pkg;

  localparam int TICK_W        = 48;
  localparam int DUR_W         = 32;
  localparam int HELD_W        = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  typedef struct packed {
    logic [TICK_W-1:0] start_time;
    logic [TICK_W-1:0] end_time;
  } swds_in_t;

  typedef struct packed {
    logic [DUR_W-1:0]  mean_time;
    logic [DUR_W-1:0]  min_time;
    logic [DUR_W-1:0]  max_time;
    logic [HELD_W-1:0] samples_held;
  } swds_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } swds_state_t;

endpackage

// ===== sv/sliding_window_duration_stats_core.sv =====
// Sliding-window duration statistics: ring store, serial scan and serial mean divide.
// Per sample: ring write, scan of the held entries for sum, min and max, divide of the
//   SUM_W = 32 + clog2(WINDOW_DEPTH+1) bit sum by the count held, then the stats beat is
//   loaded; no new sample is taken before then. The scan reads one ring entry per cycle
//   through the single memory read port and the divider retires one quotient bit per cycle.
// Reset clears write position, fill count, sequencer and stats valid; ring contents are not
//   cleared, only written slots are ever read.
module sliding_window_duration_stats_core
  import swds_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_ready,
  input  swds_in_t  sample,
  output logic      stats_valid,
  input  logic      stats_ready,
  output swds_out_t stats
);

  localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = DUR_W + CNT_W;

  swds_state_t state, state_next;

  logic [DUR_W-1:0] mem [WINDOW_DEPTH];
  logic [DUR_W-1:0] rd_data;

  logic [AW-1:0]    wpos;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] idx;
  logic [DUR_W-1:0] dur;
  logic [DUR_W-1:0] dur_new;
  logic [TICK_W:0]  diff;
  logic [SUM_W-1:0] sum;
  logic [DUR_W-1:0] lo;
  logic [DUR_W-1:0] hi;
  logic [DUR_W-1:0] mean;
  logic             first;
  logic             rd_pend;
  logic             rd_en;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic             out_load;

  assign sample_ready = (state == ST_IDLE);

  always_comb begin
    diff = {1'b0, sample.end_time} - {1'b0, sample.start_time};
    if (diff[TICK_W]) begin
      dur_new = '0;
    end else if (|diff[TICK_W-1:DUR_W]) begin
      dur_new = DUR_MAX;
    end else begin
      dur_new = diff[DUR_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx < fill) rd_en = 1'b1;
        else state_next = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!stats_valid || stats_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wpos        <= '0;
      fill        <= '0;
      rd_pend     <= 1'b0;
      stats_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (state == ST_WRITE) begin
        wpos <= (wpos == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos + 1'b1;
        if (fill != CNT_W'(WINDOW_DEPTH)) fill <= fill + 1'b1;
      end
      if (out_load) stats_valid <= 1'b1;
      else if (stats_ready) stats_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) mem[wpos] <= dur;
    if (rd_en) rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) dur <= dur_new;
    if (state == ST_WRITE) begin
      idx   <= '0;
      sum   <= '0;
      first <= 1'b1;
    end
    if (rd_en) idx <= idx + 1'b1;
    if (rd_pend) begin
      sum   <= sum + SUM_W'(rd_data);
      first <= 1'b0;
      if (first || rd_data < lo) lo <= rd_data;
      if (first || rd_data > hi) hi <= rd_data;
    end
    if (state == ST_DIV && div_done) mean <= div_quo[DUR_W-1:0];
    if (out_load) begin
      stats.mean_time    <= mean;
      stats.min_time     <= lo;
      stats.max_time     <= hi;
      stats.samples_held <= HELD_W'(fill);
    end
  end

  swds_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (sum),
    .den  (fill),
    .done (div_done),
    .quo  (div_quo)
  );

endmodule

// ===== sv/swds_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module swds_div
  import swds_pkg::*;
#(
  parameter int NUM_W = 37,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             take;

  always_comb begin
    rem_sh  = {rem, q[NUM_W-1]};
    take    = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (take) begin
        rem <= rem_sub[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = q;

endmodule

// ===== sv/swds_chk.sv =====
// Port-level checker for the duration statistics core, bound to sliding_window_duration_stats_core.
module swds_chk
  import swds_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  input logic      sample_valid,
  input logic      sample_ready,
  input logic      stats_valid,
  input logic      stats_ready,
  input swds_out_t stats
);

  localparam bit HELD_FITS = (WINDOW_DEPTH < (1 << HELD_W));

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while previous beat in progress");

  a_order: assert property (@(posedge clk) disable iff (rst)
    stats_valid |-> (stats.min_time <= stats.mean_time) &&
                    (stats.mean_time <= stats.max_time))
    else $error("mean outside min/max range");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    stats_valid && HELD_FITS |->
      (stats.samples_held != '0) && (stats.samples_held <= HELD_W'(WINDOW_DEPTH)))
    else $error("held count out of range");

  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    stats_valid && !stats_ready |=> stats_valid && $stable(stats))
    else $error("stats beat dropped or changed while stalled");

endmodule

bind sliding_window_duration_stats_core swds_chk #(
  .WINDOW_DEPTH(WINDOW_DEPTH)
) u_swds_chk (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .stats_valid (stats_valid),
  .stats_ready (stats_ready),
  .stats       (stats)
);

// ===== tb/sliding_window_duration_stats_core_test.sv =====
// Self-checking testbench for the sliding-window duration statistics core.
module sliding_window_duration_stats_core_test;
  import swds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WINDOW         = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_BEATS   = 800;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  class window_stats_scoreboard;
    logic [DUR_W-1:0]  ring [WINDOW];
    int unsigned       wr_slot;
    int unsigned       held;
    swds_out_t         stats_q[$];
    int unsigned       mismatches;

    function new();
      wr_slot    = 0;
      held       = 0;
      mismatches = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function int unsigned pending();
      return stats_q.size();
    endfunction

    function void note_sample(swds_in_t s);
      logic [TICK_W-1:0] span;
      logic [DUR_W-1:0]  dur;
      logic [63:0]       total;
      logic [DUR_W-1:0]  lo;
      logic [DUR_W-1:0]  hi;
      logic [63:0]       quot;
      swds_out_t         exp_stats;
      if (s.end_time < s.start_time) begin
        dur = '0;
      end else begin
        span = s.end_time - s.start_time;
        dur  = (span > TICK_W'(DUR_MAX)) ? DUR_MAX : span[DUR_W-1:0];
      end
      ring[wr_slot] = dur;
      wr_slot = (wr_slot + 1) % WINDOW;
      if (held < WINDOW) held++;
      total = '0;
      lo    = ring[0];
      hi    = ring[0];
      for (int i = 0; i < held; i++) begin
        total += 64'(ring[i]);
        if (ring[i] < lo) lo = ring[i];
        if (ring[i] > hi) hi = ring[i];
      end
      quot = total / 64'(held);
      exp_stats.mean_time    = quot[DUR_W-1:0];
      exp_stats.min_time     = lo;
      exp_stats.max_time     = hi;
      exp_stats.samples_held = HELD_W'(held);
      stats_q.push_back(exp_stats);
    endfunction

    function void check_stats(swds_out_t got);
      swds_out_t want;
      if (stats_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected stats beat: mean %0d min %0d max %0d held %0d",
                   got.mean_time, got.min_time, got.max_time, got.samples_held);
        mismatches++;
        return;
      end
      want = stats_q.pop_front();
      if (got.mean_time !== want.mean_time || got.min_time !== want.min_time ||
          got.max_time !== want.max_time || got.samples_held !== want.samples_held) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("stats mismatch: expected mean %0d min %0d max %0d held %0d",
                   want.mean_time, want.min_time, want.max_time, want.samples_held);
          $display("                actual   mean %0d min %0d max %0d held %0d",
                   got.mean_time, got.min_time, got.max_time, got.samples_held);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_ready;
  swds_in_t  sample       = '0;
  logic      stats_valid;
  logic      stats_ready  = 1'b0;
  swds_out_t stats;

  window_stats_scoreboard sb = new();
  bit hold_request = 1'b0;

  sliding_window_duration_stats_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .stats_valid  (stats_valid),
    .stats_ready  (stats_ready),
    .stats        (stats)
  );

  always #4 clk = ~clk;

  function automatic logic [TICK_W-1:0] random_tick();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TICK_W-1:0];
  endfunction

  function automatic swds_in_t make_sample(logic [TICK_W-1:0] t0, logic [TICK_W-1:0] t1);
    swds_in_t s;
    s.start_time = t0;
    s.end_time   = t1;
    return s;
  endfunction

  function automatic swds_in_t random_sample();
    logic [TICK_W-1:0] t0;
    logic [TICK_W-1:0] span;
    t0 = random_tick();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: span = TICK_W'($urandom_range(0, 5000));
      4, 5:       span = TICK_W'($urandom);
      6:          span = TICK_W'(DUR_MAX) - 2 + TICK_W'($urandom_range(0, 4));
      7:          span = random_tick();
      8:          span = -TICK_W'($urandom_range(1, 1000));
      default:    return make_sample(t0, random_tick());
    endcase
    return make_sample(t0, t0 + span);
  endfunction

  task automatic send_sample(swds_in_t s);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_ready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic idle_sender(int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    sample_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && stats_valid === 1'b1 && stats_ready === 1'b1) sb.check_stats(stats);
  end

  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned phase;
    phase = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(5, 120);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          stats_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        phase++;
        case (mode)
          0:       stats_ready <= 1'b1;
          1:       stats_ready <= 1'($urandom_range(0, 1));
          2:       stats_ready <= ($urandom_range(0, 3) == 0);
          default: stats_ready <= (phase % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_valid === 1'b1 && sample_ready === 1'b1) ||
          (stats_valid === 1'b1 && stats_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    swds_in_t    directed_q[$];
    logic [TICK_W-1:0] t0;
    int unsigned sent;
    int unsigned burst;
    bit          held_off;

    directed_q.push_back(make_sample('0, '0));
    directed_q.push_back(make_sample('0, 1));
    directed_q.push_back(make_sample('0, TICK_MAX));
    directed_q.push_back(make_sample(TICK_MAX, '0));
    directed_q.push_back(make_sample(TICK_MAX, TICK_MAX));
    directed_q.push_back(make_sample(5, 4));
    directed_q.push_back(make_sample(100, 100 + TICK_W'(DUR_MAX)));
    directed_q.push_back(make_sample(100, 101 + TICK_W'(DUR_MAX)));
    directed_q.push_back(make_sample(7, 6 + TICK_W'(DUR_MAX)));
    directed_q.push_back(make_sample(TICK_MAX - TICK_W'(DUR_MAX), TICK_MAX));
    for (int i = 0; i < 12; i++) begin
      t0 = i[0] ? 48'h5555_5555_5555 : 48'hAAAA_AAAA_AAAA;
      if (i % 4 == 3)
        directed_q.push_back(make_sample(t0, t0 + TICK_W'(i)));
      else
        directed_q.push_back(make_sample(t0 ^ TICK_W'(i), t0 + TICK_W'(DUR_MAX) + TICK_W'(i)));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) begin
      send_sample(directed_q[i]);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 70));
    end

    sent     = 0;
    held_off = 1'b0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 30);
      if (!held_off && sent >= 300) begin
        held_off     = 1'b1;
        hold_request = 1'b1;
        burst = 12;
      end
      for (int i = 0; i < burst && sent < RANDOM_BEATS; i++) begin
        send_sample(random_sample());
        sent++;
      end
      if (sent >= 500 && sent < 500 + 30) begin
        idle_sender(1);
        while (sb.pending() != 0) @(negedge clk);
      end
      case ($urandom_range(0, 3))
        0:       ;
        1:       idle_sender($urandom_range(1, 10));
        default: idle_sender($urandom_range(1, 80));
      endcase
    end

    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
